FILE: design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master engine package
// Shared widths, reset values, register indexes and the state and event
// types used by the engine logic and the top level.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   // Field widths.
   localparam int HALF_W     = 16;
   localparam int RETRY_W    = 10;
   localparam int COUNT_W    = 16;
   localparam int BYTE_W     = 8;
   localparam int BIT_IDX_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Default width of the half-period tick counter.
   localparam int TICK_BITS_DEFAULT = 16;

   // Register reset values and limits.
   localparam logic [HALF_W-1:0]  HALF_RESET  = 16'd400;
   localparam logic [RETRY_W-1:0] RETRY_RESET = 10'd1000;
   localparam logic [RETRY_W-1:0] RETRY_MAX   = 10'd1023;

   // Bits per byte on the bus, and the mask that clears the R/W bit.
   localparam logic [BIT_IDX_W-1:0] BITS_PER_BYTE = 4'd8;
   localparam logic [BIT_IDX_W-1:0] LAST_BIT      = 4'd7;
   localparam logic [BYTE_W-1:0]    ADDR_MASK     = 8'hFE;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT = 2'd1;

   // Bus sequencer phases.
   typedef enum logic [4:0] {
      PH_IDLE    = 5'd0,
      PH_STOP_A  = 5'd1,
      PH_STOP_B  = 5'd2,
      PH_STOP_C  = 5'd3,
      PH_STOP_D  = 5'd4,
      PH_START_A = 5'd5,
      PH_START_B = 5'd6,
      PH_START_C = 5'd7,
      PH_TX_A    = 5'd8,
      PH_TX_B    = 5'd9,
      PH_TX_C    = 5'd10,
      PH_ACK_A   = 5'd11,
      PH_ACK_B   = 5'd12,
      PH_ACK_C   = 5'd13,
      PH_RX_A    = 5'd14,
      PH_RX_B    = 5'd15,
      PH_MACK_A  = 5'd16,
      PH_MACK_B  = 5'd17,
      PH_MACK_C  = 5'd18,
      PH_MACK_D  = 5'd19
   } phase_type;

   // Transaction stage.
   typedef enum logic [1:0] {
      STG_PRE  = 2'd0,
      STG_ADDR = 2'd1,
      STG_DATA = 2'd2,
      STG_END  = 2'd3
   } stage_type;

   // Configuration registers.
   typedef struct packed {
      logic [HALF_W-1:0]  half_period;
      logic [RETRY_W-1:0] retry_limit;
   } cfg_type;

   // Transaction state, apart from the tick counter.
   typedef struct packed {
      phase_type            phase;
      stage_type            stage;
      logic                 fail;
      logic [BIT_IDX_W-1:0] bit_index;
      logic [BYTE_W-1:0]    shift_byte;
      logic [COUNT_W-1:0]   bytes_left;
      logic [RETRY_W-1:0]   retries_used;
      logic [BYTE_W-1:0]    addr_byte;
      logic                 is_read;
      logic                 scl_level;
      logic                 sda_level;
   } state_type;

   // Per-tick events.
   typedef struct packed {
      logic              tx_taken;
      logic [BYTE_W-1:0] rx_data;
      logic              rx_valid;
      logic              rx_last;
      logic              done;
      logic              status;
   } event_type;

endpackage

FILE: design/i2cm_if.sv
// ----------------------------------------------------------------------------
// I2C master engine channels
// Valid/ready channels for tick requests, tick results and register writes.
// ----------------------------------------------------------------------------

// Request channel: one tick with an optional start request.
interface i2cm_req_if
   import i2cm_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [BYTE_W-1:0]   slave_addr;
   logic                read_not_write;
   logic [COUNT_W-1:0]  byte_count;
   logic [BYTE_W-1:0]   tx_data;
   logic                sda_in;

   modport source (output valid, req_type, slave_addr, read_not_write, byte_count,
                   tx_data, sda_in, input ready);
   modport sink (input valid, req_type, slave_addr, read_not_write, byte_count,
                 tx_data, sda_in, output ready);
endinterface

// Result channel: bus drive and events of one tick.
interface i2cm_rsp_if
   import i2cm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              scl_out;
   logic              sda_out;
   logic              tx_taken;
   logic [BYTE_W-1:0] rx_data;
   logic              rx_valid;
   logic              rx_last;
   logic              busy_res;
   logic              done_res;
   logic              status;

   modport source (output valid, scl_out, sda_out, tx_taken, rx_data, rx_valid,
                   rx_last, busy_res, done_res, status, input ready);
   modport sink (input valid, scl_out, sda_out, tx_taken, rx_data, rx_valid,
                 rx_last, busy_res, done_res, status, output ready);
endinterface

// Register write channel.
interface i2cm_csr_if
   import i2cm_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: design/i2cm_engine.sv
// ----------------------------------------------------------------------------
// I2C master engine step logic
// Combinational next state of the bus sequencer for one clock tick: tick
// divider, phase transitions, shift register, counters and events.
// ----------------------------------------------------------------------------
module i2cm_engine
   import i2cm_pkg::*;
#(
   parameter int TickCounterBits = TICK_BITS_DEFAULT
) (
   input  state_type                  state_ff,
   input  logic [TickCounterBits-1:0] tick_ff,
   input  cfg_type                    cfg,
   input  logic                       start,
   input  logic [BYTE_W-1:0]          slave_addr,
   input  logic                       read_not_write,
   input  logic [COUNT_W-1:0]         byte_count,
   input  logic [BYTE_W-1:0]          tx_data,
   input  logic                       sda_in,
   output state_type                  state_in,
   output logic [TickCounterBits-1:0] tick_in,
   output event_type                  events
);

   localparam int CmpW = (TickCounterBits > HALF_W) ? TickCounterBits : HALF_W;

   logic [CmpW-1:0]            half_raw;
   logic [CmpW-1:0]            count_max;
   logic [CmpW-1:0]            half_eff;
   logic [TickCounterBits-1:0] tick_inc;
   logic                       fire;
   logic [BIT_IDX_W-1:0]       bit_inc;
   logic [RETRY_W-1:0]         retries_inc;
   logic [COUNT_W-1:0]         bytes_dec;
   logic                       retry_fail;
   logic [BYTE_W-1:0]          rx_shift;
   phase_type                  phase_in;

   // Half-period divider: zero counts as one, and the limit is clipped to
   // the largest value the tick counter can hold.
   always_comb begin
      half_raw  = (cfg.half_period == '0) ? CmpW'(1) : CmpW'(cfg.half_period);
      count_max = CmpW'({TickCounterBits{1'b1}});
      half_eff  = (half_raw > count_max) ? count_max : half_raw;
      tick_inc  = tick_ff + TickCounterBits'(1);
      fire      = (state_ff.phase != PH_IDLE) && (CmpW'(tick_inc) >= half_eff);
   end

   // Shared increments and decrements.
   always_comb begin
      bit_inc     = state_ff.bit_index + BIT_IDX_W'(1);
      retries_inc = (state_ff.retries_used < RETRY_MAX) ?
                    state_ff.retries_used + RETRY_W'(1) : state_ff.retries_used;
      retry_fail  = (retries_inc >= cfg.retry_limit);
      bytes_dec   = (state_ff.bytes_left != '0) ?
                    state_ff.bytes_left - COUNT_W'(1) : state_ff.bytes_left;
      rx_shift    = {state_ff.shift_byte[BYTE_W-2:0], sda_in};
   end

   // Tick counter restarts on a start request and after each bus action.
   always_comb begin
      if (state_ff.phase == PH_IDLE || fire) begin
         tick_in = '0;
      end else begin
         tick_in = tick_inc;
      end
   end

   // Next phase.
   always_comb begin
      phase_in = state_ff.phase;
      if (state_ff.phase == PH_IDLE) begin
         if (start) begin
            phase_in = read_not_write ? PH_START_B : PH_STOP_B;
         end
      end else if (fire) begin
         unique case (state_ff.phase)
            PH_STOP_A:  phase_in = PH_STOP_B;
            PH_STOP_B:  phase_in = PH_STOP_C;
            PH_STOP_C:  phase_in = PH_STOP_D;
            PH_STOP_D:  phase_in = (state_ff.stage == STG_PRE) ? PH_START_A : PH_IDLE;
            PH_START_A: phase_in = PH_START_B;
            PH_START_B: phase_in = PH_START_C;
            PH_START_C: phase_in = PH_TX_A;
            PH_TX_A:    phase_in = PH_TX_B;
            PH_TX_B:    phase_in = PH_TX_C;
            PH_TX_C:    phase_in = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_A : PH_TX_A;
            PH_ACK_A:   phase_in = PH_ACK_B;
            PH_ACK_B:   phase_in = PH_ACK_C;
            PH_ACK_C: begin
               if (state_ff.is_read) begin
                  phase_in = (sda_in || state_ff.bytes_left == '0) ? PH_STOP_A : PH_RX_A;
               end else if (sda_in) begin
                  if (state_ff.stage == STG_ADDR && !retry_fail) begin
                     phase_in = PH_START_A;
                  end else begin
                     phase_in = PH_STOP_A;
                  end
               end else begin
                  phase_in = (state_ff.bytes_left == '0) ? PH_STOP_A : PH_TX_A;
               end
            end
            PH_RX_A:    phase_in = PH_RX_B;
            PH_RX_B:    phase_in = (bit_inc >= BITS_PER_BYTE) ? PH_MACK_A : PH_RX_A;
            PH_MACK_A:  phase_in = PH_MACK_B;
            PH_MACK_B:  phase_in = PH_MACK_C;
            PH_MACK_C:  phase_in = PH_MACK_D;
            PH_MACK_D:  phase_in = (bytes_dec == '0) ? PH_STOP_A : PH_RX_A;
            default:    phase_in = PH_IDLE;
         endcase
      end
   end

   // Datapath, line levels and events.
   always_comb begin
      state_in.phase        = phase_in;
      state_in.stage        = state_ff.stage;
      state_in.fail         = state_ff.fail;
      state_in.bit_index    = state_ff.bit_index;
      state_in.shift_byte   = state_ff.shift_byte;
      state_in.bytes_left   = state_ff.bytes_left;
      state_in.retries_used = state_ff.retries_used;
      state_in.addr_byte    = state_ff.addr_byte;
      state_in.is_read      = state_ff.is_read;
      state_in.scl_level    = state_ff.scl_level;
      state_in.sda_level    = state_ff.sda_level;
      events                = '0;

      if (state_ff.phase == PH_IDLE) begin
         // A start request latches the transaction and makes its first move:
         // a read begins the start condition, a write begins a stop.
         if (start) begin
            state_in.addr_byte    = slave_addr & ADDR_MASK;
            state_in.is_read      = read_not_write;
            state_in.bytes_left   = byte_count;
            state_in.retries_used = '0;
            state_in.fail         = 1'b0;
            state_in.bit_index    = '0;
            state_in.shift_byte   = '0;
            if (read_not_write) begin
               state_in.stage     = STG_ADDR;
               state_in.sda_level = 1'b1;
               state_in.scl_level = 1'b1;
            end else begin
               state_in.stage     = STG_PRE;
               state_in.sda_level = 1'b0;
            end
         end
      end else if (fire) begin
         case (state_ff.phase)
            PH_STOP_A:  state_in.sda_level = 1'b0;
            PH_STOP_B:  state_in.scl_level = 1'b1;
            PH_STOP_C:  state_in.sda_level = 1'b1;
            PH_STOP_D: begin
               if (state_ff.stage == STG_PRE) begin
                  state_in.stage = STG_ADDR;
               end else begin
                  events.done   = 1'b1;
                  events.status = state_ff.fail;
               end
            end
            PH_START_A: begin
               state_in.sda_level = 1'b1;
               state_in.scl_level = 1'b1;
            end
            PH_START_B: state_in.sda_level = 1'b0;
            PH_START_C: begin
               state_in.scl_level  = 1'b0;
               state_in.shift_byte = state_ff.addr_byte | BYTE_W'(state_ff.is_read);
               state_in.bit_index  = '0;
               state_in.stage      = STG_ADDR;
            end
            PH_TX_A:    state_in.sda_level = state_ff.shift_byte[BYTE_W-1];
            PH_TX_B:    state_in.scl_level = 1'b1;
            PH_TX_C: begin
               state_in.scl_level = 1'b0;
               if (state_ff.bit_index == LAST_BIT) begin
                  state_in.sda_level = 1'b1;
               end
               state_in.shift_byte = {state_ff.shift_byte[BYTE_W-2:0], 1'b0};
               state_in.bit_index  = bit_inc;
            end
            PH_ACK_A:   state_in.sda_level = 1'b1;
            PH_ACK_B:   state_in.scl_level = 1'b1;
            PH_ACK_C: begin
               state_in.scl_level = 1'b0;
               if (state_ff.is_read) begin
                  if (sda_in) begin
                     state_in.stage = STG_END;
                     state_in.fail  = 1'b1;
                  end else if (state_ff.bytes_left == '0) begin
                     state_in.stage = STG_END;
                     state_in.fail  = 1'b0;
                  end else begin
                     state_in.stage      = STG_DATA;
                     state_in.shift_byte = '0;
                     state_in.bit_index  = '0;
                  end
               end else if (sda_in) begin
                  // Address NACK on a write retries until the limit is reached; a data NACK fails.
                  if (state_ff.stage == STG_ADDR) begin
                     state_in.retries_used = retries_inc;
                     if (retry_fail) begin
                        state_in.stage = STG_END;
                        state_in.fail  = 1'b1;
                     end
                  end else begin
                     state_in.stage = STG_END;
                     state_in.fail  = 1'b1;
                  end
               end else if (state_ff.bytes_left == '0) begin
                  state_in.stage = STG_END;
                  state_in.fail  = 1'b0;
               end else begin
                  state_in.shift_byte = tx_data;
                  events.tx_taken     = 1'b1;
                  state_in.bytes_left = state_ff.bytes_left - COUNT_W'(1);
                  state_in.stage      = STG_DATA;
                  state_in.bit_index  = '0;
               end
            end
            PH_RX_A:    state_in.scl_level = 1'b1;
            PH_RX_B: begin
               state_in.shift_byte = rx_shift;
               state_in.scl_level  = 1'b0;
               state_in.bit_index  = bit_inc;
               if (bit_inc >= BITS_PER_BYTE) begin
                  events.rx_valid = 1'b1;
                  events.rx_data  = rx_shift;
                  events.rx_last  = (state_ff.bytes_left == COUNT_W'(1));
               end
            end
            PH_MACK_A:  state_in.sda_level = (state_ff.bytes_left <= COUNT_W'(1));
            PH_MACK_B:  state_in.scl_level = 1'b1;
            PH_MACK_C:  state_in.scl_level = 1'b0;
            PH_MACK_D: begin
               state_in.sda_level  = 1'b1;
               state_in.bytes_left = bytes_dec;
               if (bytes_dec == '0) begin
                  state_in.stage = STG_END;
                  state_in.fail  = 1'b0;
               end else begin
                  state_in.shift_byte = '0;
                  state_in.bit_index  = '0;
               end
            end
            default: begin
               state_in.scl_level = 1'b1;
               state_in.sda_level = 1'b1;
            end
         endcase
      end
   end

endmodule

FILE: design/i2cm_engine_core_top.sv
// ----------------------------------------------------------------------------
// I2C master transaction engine
// Each request transfer is one clock tick of the bus engine and yields
// exactly one response transfer, held in the result register. A new
// request is taken every cycle as long as the response register is empty
// or is being emptied in the same cycle, so the sustained rate is one
// tick per clock; the only feedback path is the registered step of the
// engine state. SCL half periods last half_period request ticks, where
// a setting of zero counts as one. Register writes are accepted in every cycle.
// ----------------------------------------------------------------------------
module i2c_master_transaction_engine_core
   import i2cm_pkg::*;
#(
   parameter int TickCounterBits = TICK_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   i2cm_req_if.sink   req_chan,
   i2cm_rsp_if.source rsp_chan,
   i2cm_csr_if.sink   csr_chan
);

   cfg_type                    cfg_ff;
   state_type                  state_ff;
   state_type                  state_in;
   logic [TickCounterBits-1:0] tick_ff;
   logic [TickCounterBits-1:0] tick_in;
   event_type                  events;
   logic                       req_accept;
   logic                       rsp_valid_ff;
   logic                       scl_ff;
   logic                       sda_ff;
   logic                       busy_ff;
   event_type                  events_ff;

   // Register writes: an unknown index is dropped.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period <= HALF_RESET;
         cfg_ff.retry_limit <= RETRY_RESET;
      end else if (csr_chan.valid) begin
         if (csr_chan.index == CSR_HALF_PERIOD) begin
            cfg_ff.half_period <= csr_chan.data[HALF_W-1:0];
         end else if (csr_chan.index == CSR_RETRY_LIMIT) begin
            cfg_ff.retry_limit <= csr_chan.data[RETRY_W-1:0];
         end
      end
   end

   // Request transfer happens when the result register can take the result.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   i2cm_engine #(
      .TickCounterBits (TickCounterBits)
   ) u_engine (
      .state_ff       (state_ff),
      .tick_ff        (tick_ff),
      .cfg            (cfg_ff),
      .start          (req_chan.req_type),
      .slave_addr     (req_chan.slave_addr),
      .read_not_write (req_chan.read_not_write),
      .byte_count     (req_chan.byte_count),
      .tx_data        (req_chan.tx_data),
      .sda_in         (req_chan.sda_in),
      .state_in       (state_in),
      .tick_in        (tick_in),
      .events         (events)
   );

   // Engine state advances once per accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= PH_IDLE;
         state_ff.stage        <= STG_PRE;
         state_ff.fail         <= 1'b0;
         state_ff.bit_index    <= '0;
         state_ff.shift_byte   <= '0;
         state_ff.bytes_left   <= '0;
         state_ff.retries_used <= '0;
         state_ff.addr_byte    <= '0;
         state_ff.is_read      <= 1'b0;
         state_ff.scl_level    <= 1'b1;
         state_ff.sda_level    <= 1'b1;
         tick_ff               <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         scl_ff    <= state_in.scl_level;
         sda_ff    <= state_in.sda_level;
         busy_ff   <= (state_in.phase != PH_IDLE);
         events_ff <= events;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.scl_out  = scl_ff;
   assign rsp_chan.sda_out  = sda_ff;
   assign rsp_chan.tx_taken = events_ff.tx_taken;
   assign rsp_chan.rx_data  = events_ff.rx_data;
   assign rsp_chan.rx_valid = events_ff.rx_valid;
   assign rsp_chan.rx_last  = events_ff.rx_last;
   assign rsp_chan.busy_res = busy_ff;
   assign rsp_chan.done_res = events_ff.done;
   assign rsp_chan.status   = events_ff.status;

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// I2C master transaction engine testbench
// Each request transfer is one bus tick. Stimulus is built one transaction at
// a time. A planning copy of the bus sequencer picks the SDA level seen at
// acknowledge slots, so that address retries, data NACKs and reads of several
// bytes are all reached. A second copy of the sequencer runs on accepted
// ticks and predicts every response transfer, which is checked field by field.
// ----------------------------------------------------------------------------
module tb;
   import i2cm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;

   // One tick on the request channel.
   typedef struct packed {
      logic               req_type;
      logic [BYTE_W-1:0]  slave_addr;
      logic               read_not_write;
      logic [COUNT_W-1:0] byte_count;
      logic [BYTE_W-1:0]  tx_data;
      logic               sda_in;
   } tick_item_type;

   // Bus drive and events of one tick.
   typedef struct packed {
      logic              scl;
      logic              sda;
      logic              tx_taken;
      logic [BYTE_W-1:0] rx_data;
      logic              rx_valid;
      logic              rx_last;
      logic              busy;
      logic              done;
      logic              status;
   } tick_result_type;

   // Sequencer state, tick counter included (16 bits at the default width).
   typedef struct {
      phase_type          phase;
      stage_type          stage;
      logic               failed;
      logic [15:0]        ticks;
      logic [BIT_IDX_W-1:0] bit_idx;
      logic [BYTE_W-1:0]  shreg;
      logic [COUNT_W-1:0] remaining;
      logic [RETRY_W-1:0] attempts;
      logic [BYTE_W-1:0]  addr;
      logic               rd;
      logic               scl;
      logic               sda;
   } bus_model_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   i2cm_req_if req_bus ();
   i2cm_rsp_if rsp_bus ();
   i2cm_csr_if csr_bus ();

   i2c_master_transaction_engine_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tick_item_type   pending_ticks[$];
   tick_result_type results_due[$];

   bus_model_type plan_bus;
   bus_model_type check_bus;
   cfg_type    plan_cfg = '{half_period: HALF_RESET, retry_limit: RETRY_RESET};
   cfg_type    check_cfg = '{half_period: HALF_RESET, retry_limit: RETRY_RESET};

   int errors = 0;
   int items_made = 0;
   int settings_used = 0;
   int n_done = 0;
   int n_failed = 0;
   int n_rx = 0;
   int n_tx = 0;

   int  idle_left = 0;
   int  hold_left = 0;
   bit  send_burst = 1'b0;
   bit  recv_burst = 1'b0;
   int  quiet_cycles = 0;

   // ------------------------------------------------------------------------
   // Sequencer prediction
   // ------------------------------------------------------------------------
   function automatic bus_model_type bus_after_reset();
      bus_model_type st;
      st.phase     = PH_IDLE;
      st.stage     = STG_PRE;
      st.failed    = 1'b0;
      st.ticks     = '0;
      st.bit_idx   = '0;
      st.shreg     = '0;
      st.remaining = '0;
      st.attempts  = '0;
      st.addr      = '0;
      st.rd        = 1'b0;
      st.scl       = 1'b1;
      st.sda       = 1'b1;
      return st;
   endfunction

   // Every transaction ends through a stop condition.
   function automatic void close_transfer(inout bus_model_type st, input logic failed);
      st.stage  = STG_END;
      st.failed = failed;
      st.phase  = PH_STOP_A;
   endfunction

   // One bus action, taken once per half period.
   function automatic void bus_action(inout bus_model_type st, input cfg_type cfg,
                                      input logic sda, input logic [BYTE_W-1:0] tx,
                                      inout tick_result_type res);
      case (st.phase)
         PH_STOP_A: begin
            st.sda = 1'b0; st.phase = PH_STOP_B;
         end
         PH_STOP_B: begin
            st.scl = 1'b1; st.phase = PH_STOP_C;
         end
         PH_STOP_C: begin
            st.sda = 1'b1; st.phase = PH_STOP_D;
         end
         PH_STOP_D: begin
            // The leading stop of a write goes on to the address start.
            if (st.stage == STG_PRE) begin
               st.stage = STG_ADDR;
               st.phase = PH_START_A;
            end else begin
               res.done   = 1'b1;
               res.status = st.failed;
               st.phase   = PH_IDLE;
            end
         end
         PH_START_A: begin
            st.sda = 1'b1; st.scl = 1'b1; st.phase = PH_START_B;
         end
         PH_START_B: begin
            st.sda = 1'b0; st.phase = PH_START_C;
         end
         PH_START_C: begin
            st.scl     = 1'b0;
            st.shreg   = st.addr | BYTE_W'(st.rd);
            st.bit_idx = '0;
            st.stage   = STG_ADDR;
            st.phase   = PH_TX_A;
         end
         PH_TX_A: begin
            st.sda = st.shreg[BYTE_W-1]; st.phase = PH_TX_B;
         end
         PH_TX_B: begin
            st.scl = 1'b1; st.phase = PH_TX_C;
         end
         PH_TX_C: begin
            st.scl = 1'b0;
            if (st.bit_idx == LAST_BIT) st.sda = 1'b1;
            st.shreg   = st.shreg << 1;
            st.bit_idx = st.bit_idx + BIT_IDX_W'(1);
            st.phase   = (st.bit_idx >= BITS_PER_BYTE) ? PH_ACK_A : PH_TX_A;
         end
         PH_ACK_A: begin
            st.sda = 1'b1; st.phase = PH_ACK_B;
         end
         PH_ACK_B: begin
            st.scl = 1'b1; st.phase = PH_ACK_C;
         end
         PH_ACK_C: begin
            st.scl = 1'b0;
            if (st.rd) begin
               // A read gets no address retry.
               if (sda) close_transfer(st, 1'b1);
               else if (st.remaining == 0) close_transfer(st, 1'b0);
               else begin
                  st.stage   = STG_DATA;
                  st.shreg   = '0;
                  st.bit_idx = '0;
                  st.phase   = PH_RX_A;
               end
            end else if (sda) begin
               if (st.stage == STG_ADDR) begin
                  if (st.attempts < RETRY_MAX) st.attempts = st.attempts + RETRY_W'(1);
                  if (st.attempts >= cfg.retry_limit) close_transfer(st, 1'b1);
                  else st.phase = PH_START_A;
               end else begin
                  close_transfer(st, 1'b1);
               end
            end else if (st.remaining == 0) begin
               close_transfer(st, 1'b0);
            end else begin
               st.shreg     = tx;
               res.tx_taken = 1'b1;
               st.remaining = st.remaining - COUNT_W'(1);
               st.stage     = STG_DATA;
               st.bit_idx   = '0;
               st.phase     = PH_TX_A;
            end
         end
         PH_RX_A: begin
            st.scl = 1'b1; st.phase = PH_RX_B;
         end
         PH_RX_B: begin
            st.shreg   = {st.shreg[BYTE_W-2:0], sda};
            st.scl     = 1'b0;
            st.bit_idx = st.bit_idx + BIT_IDX_W'(1);
            if (st.bit_idx >= BITS_PER_BYTE) begin
               res.rx_valid = 1'b1;
               res.rx_data  = st.shreg;
               res.rx_last  = (st.remaining == 1);
               st.phase     = PH_MACK_A;
            end else begin
               st.phase = PH_RX_A;
            end
         end
         PH_MACK_A: begin
            // NACK only the final byte.
            st.sda = (st.remaining <= 1); st.phase = PH_MACK_B;
         end
         PH_MACK_B: begin
            st.scl = 1'b1; st.phase = PH_MACK_C;
         end
         PH_MACK_C: begin
            st.scl = 1'b0; st.phase = PH_MACK_D;
         end
         PH_MACK_D: begin
            st.sda = 1'b1;
            if (st.remaining > 0) st.remaining = st.remaining - COUNT_W'(1);
            if (st.remaining == 0) close_transfer(st, 1'b0);
            else begin
               st.shreg   = '0;
               st.bit_idx = '0;
               st.phase   = PH_RX_A;
            end
         end
         default: begin
            st.scl = 1'b1; st.sda = 1'b1; st.phase = PH_IDLE;
         end
      endcase
   endfunction

   // Advance the sequencer by one tick and report what the bus shows after it.
   function automatic void advance_bus(inout bus_model_type st, input cfg_type cfg,
                                       input tick_item_type it, output tick_result_type res);
      logic [15:0] span;
      span = (cfg.half_period == 0) ? 16'd1 : cfg.half_period;
      res  = '0;
      if (st.phase == PH_IDLE) begin
         if (it.req_type) begin
            st.addr      = it.slave_addr & ADDR_MASK;
            st.rd        = it.read_not_write;
            st.remaining = it.byte_count;
            st.attempts  = '0;
            st.failed    = 1'b0;
            st.bit_idx   = '0;
            st.shreg     = '0;
            st.ticks     = '0;
            st.stage     = it.read_not_write ? STG_ADDR : STG_PRE;
            st.phase     = it.read_not_write ? PH_START_A : PH_STOP_A;
            bus_action(st, cfg, it.sda_in, it.tx_data, res);
         end
      end else begin
         st.ticks = st.ticks + 16'd1;
         if (st.ticks >= span) begin
            st.ticks = '0;
            bus_action(st, cfg, it.sda_in, it.tx_data, res);
         end
      end
      res.scl  = st.scl;
      res.sda  = st.sda;
      res.busy = (st.phase != PH_IDLE);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus planning
   // ------------------------------------------------------------------------
   function automatic tick_item_type random_tick(input logic req);
      tick_item_type it;
      it.req_type       = req;
      it.slave_addr     = BYTE_W'($urandom_range(0, 255));
      it.read_not_write = 1'($urandom_range(0, 1));
      it.byte_count     = COUNT_W'($urandom_range(0, 65535));
      it.tx_data        = BYTE_W'($urandom_range(0, 255));
      it.sda_in         = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic void push_tick(input tick_item_type it);
      tick_result_type unused;
      advance_bus(plan_bus, plan_cfg, it, unused);
      pending_ticks.push_back(it);
      items_made++;
   endfunction

   // Queue one whole transaction. The slave NACKs the first addr_nacks address
   // bytes and the data byte numbered nack_byte (none when negative).
   task automatic queue_transfer(input logic [BYTE_W-1:0] addr, input logic rnw,
                                 input logic [COUNT_W-1:0] count, input int addr_nacks,
                                 input int nack_byte);
      tick_item_type it;
      phase_type  was_phase;
      stage_type  was_stage;
      int         data_acks;
      data_acks = 0;
      repeat ($urandom_range(0, 3)) push_tick(random_tick(1'b0));
      it                = random_tick(1'b1);
      it.slave_addr     = addr;
      it.read_not_write = rnw;
      it.byte_count     = count;
      push_tick(it);
      while (plan_bus.phase != PH_IDLE) begin
         // Now and then a start request arrives while busy and must be ignored.
         it = random_tick($urandom_range(0, 24) == 0);
         if (plan_bus.phase == PH_ACK_C) begin
            if (plan_bus.stage == STG_ADDR) it.sda_in = (addr_nacks > 0);
            else it.sda_in = (data_acks == nack_byte);
         end
         was_phase = plan_bus.phase;
         was_stage = plan_bus.stage;
         push_tick(it);
         if (was_phase == PH_ACK_C && plan_bus.phase != PH_ACK_C) begin
            if (was_stage == STG_ADDR) addr_nacks--;
            else data_acks++;
         end
      end
   endtask

   task automatic queue_random_transfer();
      logic               rnw;
      logic [COUNT_W-1:0] count;
      int                 nacks;
      int                 nack_at;
      rnw   = 1'($urandom_range(0, 1));
      count = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(4, 7))
                                          : COUNT_W'($urandom_range(0, 3));
      if (rnw) nacks = ($urandom_range(0, 9) == 0) ? 1 : 0;
      else nacks = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 4)) : 0;
      nack_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, count)) : -1;
      queue_transfer(BYTE_W'($urandom_range(0, 255)), rnw, count, nacks, nack_at);
   endtask

   // Wait until every queued tick has been checked, then a short pause.
   // The test is made at the falling edge, after the driver has settled.
   task automatic wait_drained();
      while (pending_ticks.size() != 0 || req_bus.valid || results_due.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   // Change the bus setting; only called while the engine is idle.
   task automatic set_bus(input logic [HALF_W-1:0] half, input logic [RETRY_W-1:0] limit);
      wait_drained();
      write_csr(CSR_HALF_PERIOD, CSR_DATA_W'(half));
      write_csr(CSR_RETRY_LIMIT, CSR_DATA_W'(limit));
      plan_cfg.half_period = half;
      plan_cfg.retry_limit = limit;
      settings_used++;
   endtask

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      tick_item_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (idle_left > 0) begin
            idle_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_ticks.size() != 0) begin
            nxt = pending_ticks.pop_front();
            req_bus.valid          <= 1'b1;
            req_bus.req_type       <= nxt.req_type;
            req_bus.slave_addr     <= nxt.slave_addr;
            req_bus.read_not_write <= nxt.read_not_write;
            req_bus.byte_count     <= nxt.byte_count;
            req_bus.tx_data        <= nxt.tx_data;
            req_bus.sda_in         <= nxt.sda_in;
            if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
            idle_left = send_burst ? 0 : $urandom_range(0, 5);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response ready: a random stall after each transfer, with stall-free runs.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
            hold_left = recv_burst ? 0 : $urandom_range(0, 5);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor and checker
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                              input logic [BYTE_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      tick_item_type   seen;
      tick_result_type want;
      tick_result_type got;
      if (!reset) begin
         // Register writes take effect in the predictor as they are accepted.
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_HALF_PERIOD: check_cfg.half_period = csr_bus.data[HALF_W-1:0];
               CSR_RETRY_LIMIT: check_cfg.retry_limit = csr_bus.data[RETRY_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.req_type       = req_bus.req_type;
            seen.slave_addr     = req_bus.slave_addr;
            seen.read_not_write = req_bus.read_not_write;
            seen.byte_count     = req_bus.byte_count;
            seen.tx_data        = req_bus.tx_data;
            seen.sda_in         = req_bus.sda_in;
            advance_bus(check_bus, check_cfg, seen, want);
            results_due.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.scl      = rsp_bus.scl_out;
            got.sda      = rsp_bus.sda_out;
            got.tx_taken = rsp_bus.tx_taken;
            got.rx_data  = rsp_bus.rx_data;
            got.rx_valid = rsp_bus.rx_valid;
            got.rx_last  = rsp_bus.rx_last;
            got.busy     = rsp_bus.busy_res;
            got.done     = rsp_bus.done_res;
            got.status   = rsp_bus.status;
            if (results_due.size() == 0) begin
               $display("%0t: response transfer with nothing expected", $realtime);
               errors++;
            end else begin
               want = results_due.pop_front();
               check_field("scl_out", BYTE_W'(want.scl), BYTE_W'(got.scl));
               check_field("sda_out", BYTE_W'(want.sda), BYTE_W'(got.sda));
               check_field("tx_taken", BYTE_W'(want.tx_taken), BYTE_W'(got.tx_taken));
               check_field("rx_data", want.rx_data, got.rx_data);
               check_field("rx_valid", BYTE_W'(want.rx_valid), BYTE_W'(got.rx_valid));
               check_field("rx_last", BYTE_W'(want.rx_last), BYTE_W'(got.rx_last));
               check_field("busy_res", BYTE_W'(want.busy), BYTE_W'(got.busy));
               check_field("done_res", BYTE_W'(want.done), BYTE_W'(got.done));
               check_field("status", BYTE_W'(want.status), BYTE_W'(got.status));
               n_done   += int'(want.done);
               n_failed += int'(want.done & want.status);
               n_rx     += int'(want.rx_valid);
               n_tx     += int'(want.tx_taken);
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
            $display("tb failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      tick_item_type it;
      req_bus.valid          = 1'b0;
      req_bus.req_type       = 1'b0;
      req_bus.slave_addr     = '0;
      req_bus.read_not_write = 1'b0;
      req_bus.byte_count     = '0;
      req_bus.tx_data        = '0;
      req_bus.sda_in         = 1'b1;
      rsp_bus.ready          = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.index          = '0;
      csr_bus.data           = '0;
      plan_bus  = bus_after_reset();
      check_bus = bus_after_reset();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Idle ticks at the reset setting: lines released, nothing busy.
      repeat (6) push_tick(random_tick(1'b0));

      // Fastest bus, a single address attempt.
      set_bus(16'd1, 10'd1);
      queue_transfer(8'hA0, 1'b0, 16'd0, 0, -1);   // write of no data
      queue_transfer(8'h42, 1'b0, 16'd1, 0, -1);
      queue_transfer(8'hFF, 1'b0, 16'd2, 0, 1);    // second data byte refused
      queue_transfer(8'h00, 1'b0, 16'd1, 1, -1);   // address refused, no retry left
      queue_transfer(8'h91, 1'b1, 16'd0, 0, -1);   // read of no data
      queue_transfer(8'h6C, 1'b1, 16'd3, 0, -1);
      queue_transfer(8'hFE, 1'b1, 16'd1, 1, -1);   // read address refused
      queue_transfer(8'h01, 1'b1, 16'd1, 0, -1);

      // A zero half period runs as one tick; a zero limit fails on the first NACK.
      set_bus(16'd0, 10'd0);
      queue_transfer(8'h5A, 1'b0, 16'd1, 1, -1);
      queue_transfer(8'h5B, 1'b0, 16'd1, 0, -1);

      // Retries that succeed and retries that run out.
      set_bus(16'd2, 10'd3);
      queue_transfer(8'h3C, 1'b0, 16'd1, 2, -1);
      queue_transfer(8'h3D, 1'b0, 16'd1, 3, -1);
      while (items_made < 800) queue_random_transfer();

      set_bus(16'd1, RETRY_MAX);
      while (items_made < 1200) queue_random_transfer();

      set_bus(16'd3, 10'd2);
      while (items_made < 1550) queue_random_transfer();

      set_bus(16'd1, 10'd4);
      while (items_made < 1880) queue_random_transfer();

      // Slowest bus: a long read starts and is still in its start condition at the end.
      set_bus(16'hFFFF, RETRY_MAX);
      it                = random_tick(1'b1);
      it.slave_addr     = 8'hA5;
      it.read_not_write = 1'b1;
      it.byte_count     = 16'hFFFF;
      push_tick(it);
      repeat (60) push_tick(random_tick($urandom_range(0, 24) == 0));

      wait_drained();
      if (results_due.size() != 0) begin
         $display("%0t: %0d responses never arrived", $realtime, results_due.size());
         errors++;
      end
      $display("Checked %0d ticks under %0d bus settings.", items_made, settings_used);
      $display("Transactions ended: %0d (%0d failed), bytes sent %0d, bytes read %0d.",
               n_done, n_failed, n_tx, n_rx);
      if (errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
